>>> sv/point_set_symmetry_check_top_defines.svh
// ----------------------------------------------------------------------------
// Point set symmetry check - assertion macros
// Shared property forms used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef POINT_SET_SYMMETRY_CHECK_TOP_DEFINES_SVH
`define POINT_SET_SYMMETRY_CHECK_TOP_DEFINES_SVH

// same-cycle implication
`define PSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pssc: same-cycle check failed");

// next-cycle implication
`define PSSC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pssc: next-cycle check failed");

`endif

>>> sv/pssc_pkg.sv
// ----------------------------------------------------------------------------
// Point set symmetry check - package
// Register indexes, reset values and the command flags passed front to back.
// ----------------------------------------------------------------------------
package pssc_pkg;

    localparam int CFG_W   = 18;
    localparam int IDX_W   = 3;
    localparam int SHIFT_W = 16;
    localparam int TOL_W   = 16;
    localparam int OUT_W   = 16;
    localparam int SEEN_W  = 7;
    localparam int FRAC_W  = 16;

    localparam logic [IDX_W-1:0] REG_COEF_XX = 3'd0;
    localparam logic [IDX_W-1:0] REG_COEF_XY = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHIFT_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_YX = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_YY = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHIFT_Y = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOL     = 3'd6;

    localparam logic [CFG_W-1:0]   COEF_ONE  = 18'd65536;
    localparam logic [TOL_W-1:0]   TOL_RESET = 16'd1;

    typedef struct packed {
        logic wr;    // point goes into the store
        logic last;  // final point of the set
        logic ovf;   // set has overflowed so far
    } t_cmd_flags;

endpackage

>>> sv/point_set_symmetry_check_top.sv
// Points stream in one per beat and are queued, so input is taken at one
// beat a cycle while the queue has room; a point marked with tlast starts
// the check, or for a set that overflowed gives the overflow result. The
// check engine has a single read port on the point store: for each stored
// point it reads and transforms it in the fetch, multiply and sum states
// and primes the sweep, then compares one store entry a cycle until a match
// is found or every entry has missed. Exactly one result beat follows each
// final point; the next final point is held in the queue until that
// result has been taken. Configuration writes are only to be issued while
// no set is being checked.
// ----------------------------------------------------------------------------
// Point set symmetry check - top level
// Front end, command queue and check engine of the affine invariance test.
// ----------------------------------------------------------------------------
module point_set_symmetry_check_top #(
    parameter  int MAX_POINTS = 64,
    parameter  int COORD_BITS = 16,
    localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // point_x, point_y, zero fill
    input  logic [IN_W-1:0]                  s_axis_tdata,
    // last_point
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // is_symmetry, set_overflow, points_seen[6:0], zero fill
    output logic [pssc_pkg::OUT_W-1:0]       m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [pssc_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [pssc_pkg::CFG_W-1:0]       i_cfg_data
);
    import pssc_pkg::*;

    `include "point_set_symmetry_check_top_defines.svh"

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int FW   = $bits(t_cmd_flags);
    localparam int EW   = 2 * COORD_BITS + AW + CW + FW;
    localparam int QD   = 4;
    localparam int PADW = OUT_W - SEEN_W - 2;

    logic                         f_push;
    t_cmd_flags                   f_flags;
    logic        [AW-1:0]         f_addr;
    logic        [CW-1:0]         f_cnt;
    logic signed [COORD_BITS-1:0] f_x, f_y;

    logic                         q_full;
    logic                         q_valid;
    logic                         q_pop;
    logic        [EW-1:0]         q_wdata;
    logic        [EW-1:0]         q_rdata;

    t_cmd_flags                   b_flags;
    logic        [AW-1:0]         b_addr;
    logic        [CW-1:0]         b_cnt;
    logic signed [COORD_BITS-1:0] b_x, b_y;

    logic                         r_sym;
    logic                         r_ovf;
    logic        [SEEN_W-1:0]     r_seen;

    pssc_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[COORD_BITS-1:0]),
        .i_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_last  (s_axis_tlast),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_flags (f_flags),
        .o_addr  (f_addr),
        .o_cnt   (f_cnt),
        .o_x     (f_x),
        .o_y     (f_y)
    );

    assign q_wdata = {f_flags, f_cnt, f_addr, f_y, f_x};

    pssc_queue #(
        .W     (EW),
        .DEPTH (QD)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    assign {b_flags, b_cnt, b_addr, b_y, b_x} = q_rdata;

    pssc_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_flags        (b_flags),
        .i_addr         (b_addr),
        .i_cnt          (b_cnt),
        .i_x            (b_x),
        .i_y            (b_y),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_is_symmetry  (r_sym),
        .o_set_overflow (r_ovf),
        .o_points_seen  (r_seen)
    );

    assign m_axis_tdata = {PADW'(0), r_seen, r_ovf, r_sym};

    // an overflowed set never reports a symmetry
    `PSSC_ASSERT_IMP(a_ovf_not_sym, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0])
    // a final point is not taken from the queue while a result is pending, so valid drops after each accepted result
    `PSSC_ASSERT_NXT(a_result_gap, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
    // the engine only pops a queue that holds a command
    `PSSC_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, q_pop, q_valid)

endmodule

>>> sv/pssc_front.sv
// ----------------------------------------------------------------------------
// Point set symmetry check - front end
// Accepts points, assigns store slots and tracks fill and overflow per set.
// ----------------------------------------------------------------------------
module pssc_front #(
    parameter  int MAX_POINTS = 64,
    parameter  int COORD_BITS = 16,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic                         i_last,
    input  logic                         i_full,
    output logic                         o_push,
    output pssc_pkg::t_cmd_flags         o_flags,
    output logic        [AW-1:0]         o_addr,
    output logic        [CW-1:0]         o_cnt,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);
    import pssc_pkg::*;

    logic [CW-1:0] r_cnt;
    logic          r_ovf;
    logic          has_room;

    assign has_room     = r_cnt < CW'(MAX_POINTS);
    assign o_ready      = !i_full;
    assign o_push       = i_valid && !i_full;
    assign o_flags.wr   = has_room;
    assign o_flags.last = i_last;
    assign o_flags.ovf  = r_ovf || !has_room;
    assign o_addr       = r_cnt[AW-1:0];
    assign o_cnt        = has_room ? r_cnt + CW'(1) : r_cnt;
    assign o_x          = i_x;
    assign o_y          = i_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (o_push) begin
            if (i_last) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= o_cnt;
                r_ovf <= o_flags.ovf;
            end
        end
    end

endmodule

>>> sv/pssc_queue.sv
// ----------------------------------------------------------------------------
// Point set symmetry check - command queue
// Small register FIFO between the front end and the check engine.
// ----------------------------------------------------------------------------
module pssc_queue #(
    parameter  int W     = 8,
    parameter  int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW = $clog2(DEPTH + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [LW-1:0] r_level;

    assign o_full  = r_level == LW'(DEPTH);
    assign o_valid = r_level != '0;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LW'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

endmodule

>>> sv/pssc_back.sv
// ----------------------------------------------------------------------------
// Point set symmetry check - check engine
// Holds the point store and the transform registers, runs the match sweep
// on each final point of a set that did not overflow and keeps the result in an output register.
// ----------------------------------------------------------------------------
module pssc_back #(
    parameter  int MAX_POINTS = 64,
    parameter  int COORD_BITS = 16,
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int CW = $clog2(MAX_POINTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pssc_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [pssc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  pssc_pkg::t_cmd_flags          i_flags,
    input  logic        [AW-1:0]          i_addr,
    input  logic        [CW-1:0]          i_cnt,
    input  logic signed [COORD_BITS-1:0]  i_x,
    input  logic signed [COORD_BITS-1:0]  i_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_symmetry,
    output logic                          o_set_overflow,
    output logic [pssc_pkg::SEEN_W-1:0]   o_points_seen
);
    import pssc_pkg::*;

    localparam int PRW = COORD_BITS + CFG_W;              // product
    localparam int BW  = PRW + 2;                         // biased sum
    localparam int RW  = BW - FRAC_W;                     // rounded sum
    localparam int TW  = ((RW > SHIFT_W) ? RW : SHIFT_W) + 1;
    localparam int DW  = TW + 1;                          // difference

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;

    // transform registers
    logic signed [CFG_W-1:0]   r_cxx, r_cxy, r_cyx, r_cyy;
    logic signed [SHIFT_W-1:0] r_sx, r_sy;
    logic        [TOL_W-1:0]   r_tol;

    // point store
    logic signed [COORD_BITS-1:0] r_mem_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_mem_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] r_rd_x, r_rd_y;
    logic        [AW-1:0]         rd_addr;
    logic                         wr_en;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_n, r_i, r_j;
    logic          r_cmp_vld;

    logic signed [PRW-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [BW-1:0]  bx, by;
    logic signed [RW-1:0]  rx, ry;
    logic signed [TW-1:0]  r_tx, r_ty;
    logic signed [DW-1:0]  dx, dy;
    logic        [DW-1:0]  ax, ay;
    logic                  hit;
    logic                  sweep_miss;
    logic                  finish;
    logic                  finish_sym;

    logic                  r_out_vld;
    logic                  r_out_sym;
    logic                  r_out_ovf;
    logic [SEEN_W-1:0]     r_out_seen;

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cxx <= COEF_ONE;
            r_cxy <= '0;
            r_sx  <= '0;
            r_cyx <= '0;
            r_cyy <= COEF_ONE;
            r_sy  <= '0;
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_XX: r_cxx <= i_cfg_data;
                REG_COEF_XY: r_cxy <= i_cfg_data;
                REG_SHIFT_X: r_sx  <= i_cfg_data[SHIFT_W-1:0];
                REG_COEF_YX: r_cyx <= i_cfg_data;
                REG_COEF_YY: r_cyy <= i_cfg_data;
                REG_SHIFT_Y: r_sy  <= i_cfg_data[SHIFT_W-1:0];
                REG_TOL:     r_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- queue pop: a final point waits until the previous result has gone ----
    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid && !(i_flags.last && r_out_vld);
    assign wr_en   = o_q_pop && i_flags.wr;

    // ---- store, one write port and one registered read port ----
    always_comb begin
        rd_addr = r_j[AW-1:0];
        if (r_state == ST_FETCH) begin
            rd_addr = r_i[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_x[i_addr] <= i_x;
            r_mem_y[i_addr] <= i_y;
        end
        r_rd_x <= r_mem_x[rd_addr];
        r_rd_y <= r_mem_y[rd_addr];
    end

    // ---- transform datapath ----
    always_ff @(posedge i_clk) begin
        r_pxx <= r_cxx * r_rd_x;
        r_pxy <= r_cxy * r_rd_y;
        r_pyx <= r_cyx * r_rd_x;
        r_pyy <= r_cyy * r_rd_y;
    end

    // round half up, then drop the fraction: top slice of a signed sum is a floor
    assign bx = BW'(r_pxx) + BW'(r_pxy) + BW'(32'sd32768);
    assign by = BW'(r_pyx) + BW'(r_pyy) + BW'(32'sd32768);
    assign rx = bx[BW-1:FRAC_W];
    assign ry = by[BW-1:FRAC_W];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SUM) begin
            r_tx <= TW'(rx) + TW'(r_sx);
            r_ty <= TW'(ry) + TW'(r_sy);
        end
    end

    // ---- compare against the point read on the previous sweep beat ----
    assign dx  = DW'(r_tx) - DW'(r_rd_x);
    assign dy  = DW'(r_ty) - DW'(r_rd_y);
    assign ax  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    assign ay  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    assign hit = r_cmp_vld && (ax < DW'(r_tol)) && (ay < DW'(r_tol));

    assign sweep_miss = !r_cmp_vld && (r_j == r_n);

    always_comb begin
        n_state    = r_state;
        finish     = 1'b0;
        finish_sym = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_q_pop && i_flags.last && !i_flags.ovf) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_SWEEP;
            ST_SWEEP: begin
                if (hit) begin
                    if (r_i == r_n - CW'(1)) begin
                        finish     = 1'b1;
                        finish_sym = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end else if (sweep_miss) begin
                    finish  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_n       <= '0;
            r_i       <= '0;
            r_j       <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) begin
                r_n <= i_cnt;
                r_i <= '0;
            end
            if (r_state == ST_SWEEP && hit) begin
                r_i <= r_i + CW'(1);
            end
            if (r_state == ST_SUM) begin
                r_j       <= '0;
                r_cmp_vld <= 1'b0;
            end else if (r_state == ST_SWEEP) begin
                if (r_j != r_n) begin
                    r_j       <= r_j + CW'(1);
                    r_cmp_vld <= 1'b1;
                end else begin
                    r_cmp_vld <= 1'b0;
                end
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_q_pop && i_flags.last && i_flags.ovf) begin
            r_out_vld <= 1'b1;
        end else if (finish) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_flags.last && i_flags.ovf) begin
            r_out_sym  <= 1'b0;
            r_out_ovf  <= 1'b1;
            r_out_seen <= SEEN_W'(i_cnt);
        end else if (finish) begin
            r_out_sym  <= finish_sym;
            r_out_ovf  <= 1'b0;
            r_out_seen <= SEEN_W'(r_n);
        end
    end

    assign o_valid        = r_out_vld;
    assign o_is_symmetry  = r_out_sym;
    assign o_set_overflow = r_out_ovf;
    assign o_points_seen  = r_out_seen;

endmodule
